// ===== sv/rdss_pkg.sv =====
// Shared types, constants and lookup functions for the radix digit display block.
`default_nettype none
package rdss_pkg;

  localparam int DIGIT_COUNT = 5;
  localparam int FIELD_COUNT = 5;
  localparam int VALUE_W     = 16;
  localparam int RADIX_W     = 5;
  localparam int SEG_W       = 8;
  localparam int DIGIT_W     = 4;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = VALUE_W + RECIP_W;
  localparam int PATS_BYTES  = (DIGIT_COUNT > FIELD_COUNT) ? DIGIT_COUNT : FIELD_COUNT;
  localparam int PATS_W      = PATS_BYTES * SEG_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PATS_W-1:0]  pats;
  } beat_t;

  // clamp the programmed base into 2..16
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // ceil(2^21 / d): exact quotient for any 16-bit dividend and d in 2..16
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      5'd2:    m = 21'd1048576;
      5'd3:    m = 21'd699051;
      5'd4:    m = 21'd524288;
      5'd5:    m = 21'd419431;
      5'd6:    m = 21'd349526;
      5'd7:    m = 21'd299594;
      5'd8:    m = 21'd262144;
      5'd9:    m = 21'd233017;
      5'd10:   m = 21'd209716;
      5'd11:   m = 21'd190651;
      5'd12:   m = 21'd174763;
      5'd13:   m = 21'd161320;
      5'd14:   m = 21'd149797;
      5'd15:   m = 21'd139811;
      5'd16:   m = 21'd131072;
      default: m = 21'd131072;
    endcase
    return m;
  endfunction

  // bit 0 bottom, 1 middle, 2 top, 3 upper-left, 4 upper-right,
  // 5 lower-left, 6 lower-right, 7 spare
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] dig);
    logic [SEG_W-1:0] p;
    case (dig)
      4'h0:    p = 8'hFD;
      4'h1:    p = 8'h50;
      4'h2:    p = 8'hB7;
      4'h3:    p = 8'hD7;
      4'h4:    p = 8'hDA;
      4'h5:    p = 8'hCF;
      4'h6:    p = 8'hEF;
      4'h7:    p = 8'hD4;
      4'h8:    p = 8'hFF;
      4'h9:    p = 8'hDF;
      4'hA:    p = 8'hFE;
      4'hB:    p = 8'hEB;
      4'hC:    p = 8'hAD;
      4'hD:    p = 8'hF3;
      4'hE:    p = 8'hAF;
      4'hF:    p = 8'hAE;
      default: p = 8'hFD;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rdss_digit.sv =====
// One digit step: reciprocal multiply stage, then remainder and segment lookup stage.
`default_nettype none
module rdss_digit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rdss_pkg::RADIX_W-1:0]  radix_eff,
  input  wire logic [rdss_pkg::RECIP_W-1:0]  radix_recip,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rdss_pkg::beat_t               in_beat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rdss_pkg::beat_t                    out_beat
);

  // multiply stage
  logic                            m_vld;
  logic                            m_ready;
  logic [rdss_pkg::VALUE_W-1:0]    m_value;
  logic [rdss_pkg::VALUE_W-1:0]    m_quot;
  logic [rdss_pkg::PATS_W-1:0]     m_pats;
  logic [rdss_pkg::PROD_W-1:0]     prod;

  // remainder stage
  logic                            r_vld;
  logic                            r_ready;
  rdss_pkg::beat_t                 r_beat;
  logic [rdss_pkg::RADIX_W+rdss_pkg::VALUE_W-1:0] back;
  logic [rdss_pkg::DIGIT_W-1:0]    dig;
  logic [rdss_pkg::PATS_W-1:0]     pats_next;

  assign r_ready  = !r_vld || out_ready;
  assign m_ready  = !m_vld || r_ready;
  assign in_ready = m_ready;

  assign prod = rdss_pkg::PROD_W'(in_beat.value) * rdss_pkg::PROD_W'(radix_recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (m_ready) begin
      m_vld <= in_valid;
    end
    if (m_ready && in_valid) begin
      m_value <= in_beat.value;
      m_quot  <= prod[rdss_pkg::RECIP_SHIFT +: rdss_pkg::VALUE_W];
      m_pats  <= in_beat.pats;
    end
  end

  // remainder is below 16, so the low nibble of the difference is exact
  assign back = (rdss_pkg::RADIX_W+rdss_pkg::VALUE_W)'(m_quot)
              * (rdss_pkg::RADIX_W+rdss_pkg::VALUE_W)'(radix_eff);
  assign dig  = m_value[rdss_pkg::DIGIT_W-1:0] - back[rdss_pkg::DIGIT_W-1:0];

  always_comb begin
    pats_next = m_pats >> rdss_pkg::SEG_W;
    pats_next[rdss_pkg::DIGIT_COUNT*rdss_pkg::SEG_W-1 -: rdss_pkg::SEG_W] =
      rdss_pkg::seg_pattern(dig);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (r_ready) begin
      r_vld <= m_vld;
    end
    if (r_ready && m_vld) begin
      r_beat.value <= m_quot;
      r_beat.pats  <= pats_next;
    end
  end

  assign out_valid = r_vld;
  assign out_beat  = r_beat;

endmodule
`default_nettype wire

// ===== sv/radix_digit_seven_segment_top.sv =====
// Top level: radix register and a chain of digit steps producing five segment patterns.
// Throughput: one beat per cycle while out_ready is high; each digit is a reciprocal multiply stage
// followed by a remainder/lookup stage, and every stage stalls on its own.
// Reset (rst, synchronous): all stage valids clear, radix returns to 10.
// Config writes always taken (cfg_ready high), seen by every stage at once: write when idle.
`default_nettype none
module radix_digit_seven_segment_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rdss_pkg::RADIX_W-1:0]  cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rdss_pkg::VALUE_W-1:0]  value,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rdss_pkg::SEG_W-1:0]         seg_digit4,
  output logic [rdss_pkg::SEG_W-1:0]         seg_digit3,
  output logic [rdss_pkg::SEG_W-1:0]         seg_digit2,
  output logic [rdss_pkg::SEG_W-1:0]         seg_digit1,
  output logic [rdss_pkg::SEG_W-1:0]         seg_digit0
);

  logic [rdss_pkg::RADIX_W-1:0] radix;
  logic [rdss_pkg::RADIX_W-1:0] radix_eff;
  logic [rdss_pkg::RECIP_W-1:0] radix_recip;

  // handshake chain: index 0 is the input side, DIGIT_COUNT the output side
  logic            vld [rdss_pkg::DIGIT_COUNT+1];
  logic            rdy [rdss_pkg::DIGIT_COUNT+1];
  rdss_pkg::beat_t beat[rdss_pkg::DIGIT_COUNT+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdss_pkg::RADIX_RESET;
    end else if (cfg_valid) begin
      radix <= cfg_data;
    end
  end

  // the user must change radix only while idle (the block does not enforce it),
  // so the clamp and reciprocal lookup feed every digit step directly
  assign radix_eff   = rdss_pkg::eff_radix(radix);
  assign radix_recip = rdss_pkg::recip(radix_eff);

  // patterns start empty; each step shifts its pattern in from the top
  assign vld[0]        = in_valid;
  assign in_ready      = rdy[0];
  assign beat[0].value = value;
  assign beat[0].pats  = '0;

  for (genvar i = 0; i < rdss_pkg::DIGIT_COUNT; i++) begin : g_digit
    rdss_digit u_digit (
      .clk         (clk),
      .rst         (rst),
      .radix_eff   (radix_eff),
      .radix_recip (radix_recip),
      .in_valid    (vld[i]),
      .in_ready    (rdy[i]),
      .in_beat     (beat[i]),
      .out_valid   (vld[i+1]),
      .out_ready   (rdy[i+1]),
      .out_beat    (beat[i+1])
    );
  end

  assign out_valid                = vld[rdss_pkg::DIGIT_COUNT];
  assign rdy[rdss_pkg::DIGIT_COUNT] = out_ready;

  // digit 0 ends up in the lowest byte; fields above the digit count stay zero
  assign seg_digit0 = beat[rdss_pkg::DIGIT_COUNT].pats[0*rdss_pkg::SEG_W +: rdss_pkg::SEG_W];
  assign seg_digit1 = beat[rdss_pkg::DIGIT_COUNT].pats[1*rdss_pkg::SEG_W +: rdss_pkg::SEG_W];
  assign seg_digit2 = beat[rdss_pkg::DIGIT_COUNT].pats[2*rdss_pkg::SEG_W +: rdss_pkg::SEG_W];
  assign seg_digit3 = beat[rdss_pkg::DIGIT_COUNT].pats[3*rdss_pkg::SEG_W +: rdss_pkg::SEG_W];
  assign seg_digit4 = beat[rdss_pkg::DIGIT_COUNT].pats[4*rdss_pkg::SEG_W +: rdss_pkg::SEG_W];

endmodule
`default_nettype wire
